@@ src/rtef_pkg.sv @@
// Shared constants for the ray/tetrahedron exit face core.
// No dependencies.
package rtef_pkg;

  // Default widths of coordinates and identifiers
  localparam int COORD_BITS_DEF = 20;
  localparam int ID_BITS_DEF    = 16;

  // Fixed field formats
  localparam int FACES     = 4;
  localparam int AXES      = 3;
  localparam int DIR_BITS  = 18;  // Q1.16 direction
  localparam int NRM_BITS  = 14;  // Q1.12 normal
  localparam int PC_BITS   = 22;  // plane constant
  localparam int PLANE_W   = 64;
  localparam int DIR_FRAC  = 16;
  localparam int NRM_FRAC  = 12;
  localparam int OUT_ID_W  = 16;

endpackage

@@ src/ray_tetra_exit_face_core.sv @@
// Ray/tetrahedron exit face core: plane tests, pipelined division, minimum
// search and end point. Depends on rtef_pkg.
//
//  channel | ports                              | handshake
//  --------+------------------------------------+---------------------------
//  input   | in_*                               | start high, busy low
//  result  | out_*                              | out_valid strobe, 1 cycle
//
// One transaction enters every cycle; busy is always low.
// The pipeline has COORD_BITS + 1 stages of the restoring
// divider, which produces one quotient bit per stage for each of the four
// faces, plus six stages for products, setup, minimum, select and end point.
// rst_n clears the valid bits only; the receiver cannot stall, so the
// pipeline never holds.
module ray_tetra_exit_face_core #(
  parameter int COORD_BITS = rtef_pkg::COORD_BITS_DEF,
  parameter int ID_BITS    = rtef_pkg::ID_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [3*COORD_BITS-1:0]                in_ray_position,
  input  logic [3*rtef_pkg::DIR_BITS-1:0]        in_ray_direction,
  input  logic [COORD_BITS-1:0]                  in_step_limit,
  input  logic [rtef_pkg::PLANE_W-1:0]           in_plane_zero,
  input  logic [rtef_pkg::PLANE_W-1:0]           in_plane_one,
  input  logic [rtef_pkg::PLANE_W-1:0]           in_plane_two,
  input  logic [rtef_pkg::PLANE_W-1:0]           in_plane_three,
  input  logic [4*ID_BITS-1:0]                   in_face_ids,
  input  logic [4*ID_BITS-1:0]                   in_neighbor_ids,
  output logic                                   out_valid,
  output logic                                   out_hit,
  output logic [1:0]                             out_face_slot,
  output logic signed [rtef_pkg::OUT_ID_W-1:0]   out_exit_face,
  output logic [rtef_pkg::OUT_ID_W-1:0]          out_next_tetra,
  output logic [COORD_BITS-1:0]                  out_travel,
  output logic signed [COORD_BITS-1:0]           out_end_x,
  output logic signed [COORD_BITS-1:0]           out_end_y,
  output logic signed [COORD_BITS-1:0]           out_end_z
);
  import rtef_pkg::*;

  localparam int QB  = COORD_BITS;
  localparam int ND  = QB + 1;                       // divider stages
  localparam int DNW = NRM_BITS + DIR_BITS;          // n*d product
  localparam int NPW = NRM_BITS + COORD_BITS;        // n*p product
  localparam int DW  = DNW + 2;                      // dot sum
  localparam int CSW = PC_BITS + NRM_FRAC;           // C scaled
  localparam int HW  = ((NPW + 2) > CSW ? (NPW + 2) : CSW) + 1;
  localparam int NW  = HW + DIR_FRAC;                // dividend
  localparam int RW  = (NW > DW + QB) ? NW : DW + QB;
  localparam int MW  = DIR_BITS + COORD_BITS + 1;    // d*travel
  localparam int EW  = MW + 2;

  typedef struct packed {
    logic [3*COORD_BITS-1:0] pos;
    logic [3*DIR_BITS-1:0]   dir;
    logic [COORD_BITS-1:0]   lim;
    logic [4*ID_BITS-1:0]    fid;
    logic [4*ID_BITS-1:0]    nid;
  } ctx_t;

  assign busy = 1'b0;

  logic [PLANE_W-1:0] planes [FACES];
  assign planes[0] = in_plane_zero;
  assign planes[1] = in_plane_one;
  assign planes[2] = in_plane_two;
  assign planes[3] = in_plane_three;

  // Stage 1: products of normal with direction and position
  logic                     v1_r;
  ctx_t                     c1_r;
  logic signed [DNW-1:0]    pdn_r [FACES][AXES];
  logic signed [NPW-1:0]    pnp_r [FACES][AXES];
  logic signed [PC_BITS-1:0] pc_r [FACES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    c1_r <= '{pos: in_ray_position, dir: in_ray_direction, lim: in_step_limit,
              fid: in_face_ids, nid: in_neighbor_ids};
    for (int f = 0; f < FACES; f++) begin
      for (int k = 0; k < AXES; k++) begin
        pdn_r[f][k] <= DNW'($signed(planes[f][k*NRM_BITS +: NRM_BITS]) *
                            $signed(in_ray_direction[k*DIR_BITS +: DIR_BITS]));
        pnp_r[f][k] <= NPW'($signed(planes[f][k*NRM_BITS +: NRM_BITS]) *
                            $signed(in_ray_position[k*COORD_BITS +: COORD_BITS]));
      end
      pc_r[f] <= $signed(planes[f][AXES*NRM_BITS +: PC_BITS]);
    end
  end

  // Stage 2: dot and height, set up the dividend and divisor
  logic             vd_r [0:ND];
  ctx_t             cd_r [0:ND];
  logic [RW-1:0]    rem_r [0:ND][FACES];
  logic [DW-1:0]    div_r [0:ND][FACES];
  logic [QB:0]      quo_r [0:ND][FACES];
  logic             ok_r  [0:ND][FACES];

  logic signed [DW-1:0] dot_c [FACES];
  logic signed [HW-1:0] h_c   [FACES];
  logic signed [DW-1:0] ndot_c [FACES];
  logic signed [HW-1:0] nh_c   [FACES];

  always_comb begin
    for (int f = 0; f < FACES; f++) begin
      dot_c[f] = DW'(pdn_r[f][0]) + DW'(pdn_r[f][1]) + DW'(pdn_r[f][2]);
      h_c[f]   = (HW'(pc_r[f]) <<< NRM_FRAC)
                 - (HW'(pnp_r[f][0]) + HW'(pnp_r[f][1]) + HW'(pnp_r[f][2]));
      ndot_c[f] = -dot_c[f];
      nh_c[f]   = -h_c[f];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r[0] <= 1'b0;
    end else begin
      vd_r[0] <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    cd_r[0] <= c1_r;
    for (int f = 0; f < FACES; f++) begin
      ok_r[0][f]  <= dot_c[f][DW-1] && h_c[f][HW-1];
      div_r[0][f] <= DW'(ndot_c[f]);
      rem_r[0][f] <= RW'({nh_c[f], {DIR_FRAC{1'b0}}});
      quo_r[0][f] <= '0;
    end
  end

  // Divider: one quotient bit per stage, the top bit flags overflow
  for (genvar s = 1; s <= ND; s++) begin : g_div
    localparam int B = ND - s;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[s] <= 1'b0;
      end else begin
        vd_r[s] <= vd_r[s-1];
      end
    end
    always_ff @(posedge clk) begin
      cd_r[s] <= cd_r[s-1];
      for (int f = 0; f < FACES; f++) begin
        ok_r[s][f]  <= ok_r[s-1][f];
        div_r[s][f] <= div_r[s-1][f];
        quo_r[s][f] <= quo_r[s-1][f];
        if (rem_r[s-1][f] >= (RW'(div_r[s-1][f]) << B)) begin
          rem_r[s][f]    <= rem_r[s-1][f] - (RW'(div_r[s-1][f]) << B);
          quo_r[s][f][B] <= 1'b1;
        end else begin
          rem_r[s][f] <= rem_r[s-1][f];
        end
      end
    end
  end

  // Min stage A: form candidates and pair minima
  logic [QB-1:0] cand_c [FACES];
  always_comb begin
    for (int f = 0; f < FACES; f++) begin
      if (!ok_r[ND][f]) begin
        cand_c[f] = cd_r[ND].lim;
      end else if (quo_r[ND][f][QB]) begin
        cand_c[f] = '1;
      end else begin
        cand_c[f] = quo_r[ND][f][QB-1:0];
      end
    end
  end

  logic            va_r;
  ctx_t            ca_r;
  logic [QB-1:0]   pmin_r [2];
  logic [1:0]      pslot_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= vd_r[ND];
    end
  end

  always_ff @(posedge clk) begin
    ca_r <= cd_r[ND];
    for (int p = 0; p < 2; p++) begin
      if (cand_c[2*p+1] < cand_c[2*p]) begin
        pmin_r[p]  <= cand_c[2*p+1];
        pslot_r[p] <= 2'(2*p+1);
      end else begin
        pmin_r[p]  <= cand_c[2*p];
        pslot_r[p] <= 2'(2*p);
      end
    end
  end

  // Min stage B: final winner, hit flag and identifier select
  logic [QB-1:0] best_c;
  logic [1:0]    bslot_c;
  logic          hit_c;
  always_comb begin
    if (pmin_r[1] < pmin_r[0]) begin
      best_c  = pmin_r[1];
      bslot_c = pslot_r[1];
    end else begin
      best_c  = pmin_r[0];
      bslot_c = pslot_r[0];
    end
    hit_c = best_c < ca_r.lim;
  end

  logic                     vb_r;
  logic                     hit_b_r;
  logic [1:0]               slot_b_r;
  logic [OUT_ID_W-1:0]      fid_b_r;
  logic [OUT_ID_W-1:0]      nid_b_r;
  logic [QB-1:0]            trav_b_r;
  logic [3*COORD_BITS-1:0]  pos_b_r;
  logic [3*DIR_BITS-1:0]    dir_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    hit_b_r  <= hit_c;
    slot_b_r <= hit_c ? bslot_c : 2'b0;
    fid_b_r  <= hit_c ? OUT_ID_W'($signed(ca_r.fid[bslot_c*ID_BITS +: ID_BITS])) : '0;
    nid_b_r  <= hit_c ? OUT_ID_W'(ca_r.nid[bslot_c*ID_BITS +: ID_BITS]) : '0;
    trav_b_r <= hit_c ? best_c : ca_r.lim;
    pos_b_r  <= ca_r.pos;
    dir_b_r  <= ca_r.dir;
  end

  // Offset multiply: direction times travel
  logic                     vm_r;
  logic                     hit_m_r;
  logic [1:0]               slot_m_r;
  logic [OUT_ID_W-1:0]      fid_m_r;
  logic [OUT_ID_W-1:0]      nid_m_r;
  logic [QB-1:0]            trav_m_r;
  logic [3*COORD_BITS-1:0]  pos_m_r;
  logic signed [MW-1:0]     off_m_r [AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else begin
      vm_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    hit_m_r  <= hit_b_r;
    slot_m_r <= slot_b_r;
    fid_m_r  <= fid_b_r;
    nid_m_r  <= nid_b_r;
    trav_m_r <= trav_b_r;
    pos_m_r  <= pos_b_r;
    for (int k = 0; k < AXES; k++) begin
      off_m_r[k] <= MW'($signed(dir_b_r[k*DIR_BITS +: DIR_BITS]) *
                        $signed({1'b0, trav_b_r}));
    end
  end

  // Round, add to origin and saturate
  localparam logic signed [EW-1:0] HALF   = EW'(1) <<< (DIR_FRAC - 1);
  localparam logic signed [EW-1:0] SAT_HI = (EW'(1) <<< (COORD_BITS - 1)) - EW'(1);
  localparam logic signed [EW-1:0] SAT_LO = -(EW'(1) <<< (COORD_BITS - 1));

  logic signed [EW-1:0]          sum_c [AXES];
  logic signed [COORD_BITS-1:0]  end_c [AXES];
  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      sum_c[k] = EW'($signed(pos_m_r[k*COORD_BITS +: COORD_BITS]))
                 + ((EW'(off_m_r[k]) + HALF) >>> DIR_FRAC);
      if (sum_c[k] > SAT_HI) begin
        end_c[k] = COORD_BITS'(SAT_HI);
      end else if (sum_c[k] < SAT_LO) begin
        end_c[k] = COORD_BITS'(SAT_LO);
      end else begin
        end_c[k] = COORD_BITS'(sum_c[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    out_hit        <= hit_m_r;
    out_face_slot  <= slot_m_r;
    out_exit_face  <= fid_m_r;
    out_next_tetra <= nid_m_r;
    out_travel     <= trav_m_r;
    out_end_x      <= end_c[0];
    out_end_y      <= end_c[1];
    out_end_z      <= end_c[2];
  end

endmodule
